[rtl/swt_pkg.sv]
// Shared definitions for the staged waypoint table: opcodes, default sizes
// and the control bundle passed from the top level to the bank memory.
// No dependencies.
`timescale 1ns / 1ps

package swt_pkg;

	// Default table depth and stored coordinate width
	localparam int MAX_ENTRIES_DEF = 32;
	localparam int COORD_WIDTH_DEF = 16;

	// Fixed widths of the stream fields
	localparam int OPCODE_W = 3;
	localparam int COUNT_W  = 8;
	localparam int INDEX_W  = 8;
	localparam int XY_W     = 16;

	typedef enum logic [OPCODE_W-1:0] {
		OP_RESET  = 3'd0,
		OP_BEGIN  = 3'd1,
		OP_STORE  = 3'd2,
		OP_COMMIT = 3'd3,
		OP_GET    = 3'd4
	} swt_op_t;

	// Write and read strobes with the bank half each one addresses
	typedef struct packed {
		logic wr_en;
		logic wr_sel;
		logic rd_en;
		logic rd_sel;
	} swt_bank_ctrl_t;

endpackage

[rtl/swt_bank.sv]
// Ping-pong coordinate memory: two halves of MAX_ENTRIES x/y pairs, one write
// port and one registered read port. Depends on swt_pkg.
`timescale 1ns / 1ps

module swt_bank #(
	parameter int MAX_ENTRIES = swt_pkg::MAX_ENTRIES_DEF,
	parameter int COORD_WIDTH = swt_pkg::COORD_WIDTH_DEF,
	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
	input  logic                           clk,
	input  swt_pkg::swt_bank_ctrl_t        ctrl,
	input  logic [IDX_W-1:0]               wr_idx,
	input  logic signed [COORD_WIDTH-1:0]  wr_x,
	input  logic signed [COORD_WIDTH-1:0]  wr_y,
	input  logic [IDX_W-1:0]               rd_idx,
	output logic signed [COORD_WIDTH-1:0]  rd_x,
	output logic signed [COORD_WIDTH-1:0]  rd_y
);

	logic [2*COORD_WIDTH-1:0] mem [2][MAX_ENTRIES];

	// Write one pair into the selected half
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[ctrl.wr_sel][wr_idx] <= {wr_y, wr_x};
		end
	end

	// Register the read data; hold it while no read is issued
	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			{rd_y, rd_x} <= mem[ctrl.rd_sel][rd_idx];
		end
	end

endmodule

[rtl/staged_waypoint_table_top.sv]
// Top level of the staged waypoint table: stream ports, control state and
// result register. Depends on swt_pkg and swt_bank.
`timescale 1ns / 1ps

// The block takes one operation beat per cycle while the output is not
// stalled and returns one result beat for each: the beat is captured in an
// input register, decoded and applied to the table in one pass, and the
// result lands in the output register together with the registered read of
// the coordinate memory. The two table banks share one memory with one write
// port (store) and one read port (get); commit flips which half is active,
// so it is handled in one pass like every other opcode.
// Entries never written read as undefined data, but only written entries can
// be reached by a successful get.

module staged_waypoint_table_top #(
	parameter int MAX_ENTRIES = swt_pkg::MAX_ENTRIES_DEF,
	parameter int COORD_WIDTH = swt_pkg::COORD_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] count, [15:8] index, [31:16] x_in, [47:32] y_in
	input  logic [47:0] s_tdata,
	// [2:0] opcode
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] ok, [16:1] x_out, [32:17] y_out, [33] loaded, [41:34] active_count
	output logic [47:0] m_tdata
);

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW    = swt_pkg::COUNT_W;
	localparam int XW    = swt_pkg::XY_W;

	// Input register
	logic                          v_s1;
	logic [swt_pkg::OPCODE_W-1:0]  op_s1;
	logic [CW-1:0]                 count_s1;
	logic [swt_pkg::INDEX_W-1:0]   index_s1;
	logic signed [XW-1:0]          x_s1;
	logic signed [XW-1:0]          y_s1;

	// Table control state
	logic [CW-1:0]          expected_q;
	logic [CW-1:0]          active_cnt_q;
	logic                   loaded_q;
	logic                   receiving_q;
	logic [MAX_ENTRIES-1:0] written_q;
	logic                   active_sel_q;

	// Result register
	logic          v_s2;
	logic          ok_s2;
	logic          hit_s2;
	logic          loaded_s2;
	logic [CW-1:0] count_s2;

	logic advance;
	logic fire;

	// Next-state and result of the operation in the input register
	logic                    ok_c;
	logic                    get_hit_c;
	logic [CW-1:0]           expected_d;
	logic [CW-1:0]           active_cnt_d;
	logic                    loaded_d;
	logic                    receiving_d;
	logic [MAX_ENTRIES-1:0]  written_d;
	logic                    active_sel_d;
	logic                    all_written;
	swt_pkg::swt_bank_ctrl_t bank_ctrl;

	logic signed [COORD_WIDTH-1:0] wr_x;
	logic signed [COORD_WIDTH-1:0] wr_y;
	logic signed [COORD_WIDTH-1:0] rd_x;
	logic signed [COORD_WIDTH-1:0] rd_y;
	logic signed [XW-1:0]          x_out;
	logic signed [XW-1:0]          y_out;

	// Advance both stages together whenever the result register can move
	assign advance  = !v_s2 || m_tready;
	assign s_tready = !v_s1 || advance;
	assign fire     = v_s1 && advance;

	// Capture an accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1    <= s_tuser;
			count_s1 <= s_tdata[7:0];
			index_s1 <= s_tdata[15:8];
			x_s1     <= s_tdata[31:16];
			y_s1     <= s_tdata[47:32];
		end
	end

	// Check that every entry below the expected count has been written
	always_comb begin
		all_written = 1'b1;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if ((CW'(i) < expected_q) && !written_q[i]) begin
				all_written = 1'b0;
			end
		end
	end

	// Fit the stored coordinates to the storage width
	assign wr_x = COORD_WIDTH'(x_s1);
	assign wr_y = COORD_WIDTH'(y_s1);

	// Decode the opcode and work out the next table state
	always_comb begin
		ok_c         = 1'b0;
		get_hit_c    = 1'b0;
		expected_d   = expected_q;
		active_cnt_d = active_cnt_q;
		loaded_d     = loaded_q;
		receiving_d  = receiving_q;
		written_d    = written_q;
		active_sel_d = active_sel_q;
		bank_ctrl.wr_en  = 1'b0;
		bank_ctrl.wr_sel = !active_sel_q;
		bank_ctrl.rd_en  = fire;
		bank_ctrl.rd_sel = active_sel_q;
		case (op_s1)
			swt_pkg::OP_RESET: begin
				ok_c         = 1'b1;
				expected_d   = '0;
				active_cnt_d = '0;
				loaded_d     = 1'b0;
				receiving_d  = 1'b0;
				written_d    = '0;
			end
			swt_pkg::OP_BEGIN: begin
				if ((count_s1 != '0) && (count_s1 <= CW'(MAX_ENTRIES))) begin
					ok_c        = 1'b1;
					expected_d  = count_s1;
					receiving_d = 1'b1;
					loaded_d    = 1'b0;
					written_d   = '0;
				end
			end
			swt_pkg::OP_STORE: begin
				if (receiving_q && (index_s1 < expected_q)) begin
					ok_c            = 1'b1;
					bank_ctrl.wr_en = fire;
					written_d[index_s1[IDX_W-1:0]] = 1'b1;
				end
			end
			swt_pkg::OP_COMMIT: begin
				if (receiving_q && all_written) begin
					ok_c         = 1'b1;
					active_sel_d = !active_sel_q;
					active_cnt_d = expected_q;
					loaded_d     = 1'b1;
					receiving_d  = 1'b0;
				end
			end
			swt_pkg::OP_GET: begin
				if (index_s1 < active_cnt_q) begin
					ok_c      = 1'b1;
					get_hit_c = 1'b1;
				end
			end
			default: begin
				ok_c = 1'b0;
			end
		endcase
	end

	// Update the table state when the operation moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q   <= '0;
			active_cnt_q <= '0;
			loaded_q     <= 1'b0;
			receiving_q  <= 1'b0;
			written_q    <= '0;
			active_sel_q <= 1'b0;
		end else if (fire) begin
			expected_q   <= expected_d;
			active_cnt_q <= active_cnt_d;
			loaded_q     <= loaded_d;
			receiving_q  <= receiving_d;
			written_q    <= written_d;
			active_sel_q <= active_sel_d;
		end
	end

	swt_bank #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.COORD_WIDTH (COORD_WIDTH)
	) u_bank (
		.clk    (clk),
		.ctrl   (bank_ctrl),
		.wr_idx (index_s1[IDX_W-1:0]),
		.wr_x   (wr_x),
		.wr_y   (wr_y),
		.rd_idx (index_s1[IDX_W-1:0]),
		.rd_x   (rd_x),
		.rd_y   (rd_y)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			ok_s2     <= ok_c;
			hit_s2    <= get_hit_c;
			loaded_s2 <= loaded_d;
			count_s2  <= active_cnt_d;
		end
	end

	// Zero the data unless a get hit; report the low bits of the stored value
	assign x_out = hit_s2 ? XW'(rd_x) : '0;
	assign y_out = hit_s2 ? XW'(rd_y) : '0;

	assign m_tvalid = v_s2;
	assign m_tdata  = {6'b0, count_s2, loaded_s2, y_out, x_out, ok_s2};

endmodule
